@@ rtl/vfd_pkg.sv @@
// Shared types and constants for the vision frame deframer.
// Used by vfd_store, vfd_check_unit, vfd_ctrl and vision_frame_deframer.
`timescale 1ns / 1ps

package vfd_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 11;
    localparam int IDX_W     = $clog2(FRAME_LEN + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [7:0]       byte_t;

    localparam idx_t LEN_IDX  = idx_t'(FRAME_LEN);
    localparam idx_t LAST_IDX = idx_t'(FRAME_LEN - 1);

    // Byte positions inside a frame
    localparam idx_t HDR0_IDX  = idx_t'(0);
    localparam idx_t HDR1_IDX  = idx_t'(1);
    localparam idx_t FOUND_IDX = idx_t'(2);
    localparam idx_t CONF_IDX  = idx_t'(3);
    localparam idx_t XLO_IDX   = idx_t'(4);
    localparam idx_t XHI_IDX   = idx_t'(5);
    localparam idx_t YLO_IDX   = idx_t'(6);
    localparam idx_t YHI_IDX   = idx_t'(7);
    localparam idx_t CSUM_IDX  = idx_t'(8);
    localparam idx_t TAIL0_IDX = idx_t'(9);
    localparam idx_t TAIL1_IDX = idx_t'(10);
    localparam idx_t SUM_LAST  = YHI_IDX;

    // Field limits
    localparam byte_t FOUND_MAX = 8'd1;
    localparam byte_t CONF_MAX  = 8'd100;

    // Configuration registers
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_TAIL   = 1'b1;
    localparam byte_t HEADER_RESET = 8'd170;
    localparam byte_t TAIL_RESET   = 8'd85;

    // Result item, has_target in the lowest bit
    typedef struct packed {
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_x;
        logic [6:0]         confidence;
        logic               has_target;
    } out_item_t;

    // Sequencer to check unit
    typedef struct packed {
        logic step;
        idx_t idx;
    } chk_ctl_t;

    // Check unit to sequencer
    typedef struct packed {
        logic frame_ok;
        logic pair_found;
        idx_t pair_pos;
        logic last_hdr;
    } chk_res_t;

    // Store write port
    typedef struct packed {
        logic  we;
        idx_t  addr;
        byte_t data;
    } st_wr_t;

endpackage

@@ rtl/vfd_store.sv @@
// Frame store: 11 byte registers with one write port and one read port.
// Depends on vfd_pkg.
`timescale 1ns / 1ps

module vfd_store (
    input  logic            aclk,
    input  vfd_pkg::st_wr_t wr,
    input  vfd_pkg::idx_t   rd_addr,
    output vfd_pkg::byte_t  rd_data
);

    vfd_pkg::byte_t mem [vfd_pkg::FRAME_LEN];

    // Write one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read the addressed entry
    assign rd_data = mem[rd_addr];

endmodule

@@ rtl/vfd_check_unit.sv @@
// Shared byte check unit: one add and compare per step over the stored frame.
// Accumulates checksum, field checks, header pair search and payload. Depends on vfd_pkg.
`timescale 1ns / 1ps

module vfd_check_unit (
    input  logic                aclk,
    input  vfd_pkg::chk_ctl_t   ctl,
    input  vfd_pkg::byte_t      data,
    input  vfd_pkg::byte_t      header_byte,
    input  vfd_pkg::byte_t      tail_byte,
    output vfd_pkg::chk_res_t   res,
    output vfd_pkg::out_item_t  item
);

    vfd_pkg::byte_t     sum_reg, sum_next;
    logic               ok_reg, ok_next;
    logic               prev_hdr_reg, prev_hdr_next;
    logic               pair_found_reg, pair_found_next;
    vfd_pkg::idx_t      pair_pos_reg, pair_pos_next;
    vfd_pkg::out_item_t item_reg, item_next;

    logic is_hdr;
    logic is_tail;
    logic cond;

    assign is_hdr  = (data == header_byte);
    assign is_tail = (data == tail_byte);

    // Per-position frame check
    always_comb begin
        case (ctl.idx)
            vfd_pkg::HDR0_IDX, vfd_pkg::HDR1_IDX:   cond = is_hdr;
            vfd_pkg::FOUND_IDX:                     cond = (data <= vfd_pkg::FOUND_MAX);
            vfd_pkg::CONF_IDX:                      cond = (data <= vfd_pkg::CONF_MAX);
            vfd_pkg::CSUM_IDX:                      cond = (data == sum_reg);
            vfd_pkg::TAIL0_IDX, vfd_pkg::TAIL1_IDX: cond = is_tail;
            default:                                cond = 1'b1;
        endcase
    end

    // Accumulate over one pass
    always_comb begin
        sum_next        = sum_reg;
        ok_next         = ok_reg;
        prev_hdr_next   = prev_hdr_reg;
        pair_found_next = pair_found_reg;
        pair_pos_next   = pair_pos_reg;
        item_next       = item_reg;
        if (ctl.step) begin
            prev_hdr_next = is_hdr;
            if (ctl.idx == vfd_pkg::HDR0_IDX) begin
                sum_next        = data;
                ok_next         = cond;
                pair_found_next = 1'b0;
            end else begin
                if (ctl.idx <= vfd_pkg::SUM_LAST) begin
                    sum_next = sum_reg + data;
                end
                ok_next = ok_reg & cond;
                // First header pair starting at offset 1 or later
                if (ctl.idx >= vfd_pkg::FOUND_IDX && prev_hdr_reg && is_hdr
                    && !pair_found_reg) begin
                    pair_found_next = 1'b1;
                    pair_pos_next   = ctl.idx - vfd_pkg::idx_t'(1);
                end
            end
            // Capture payload fields as they pass
            case (ctl.idx)
                vfd_pkg::FOUND_IDX: item_next.has_target     = (data == vfd_pkg::FOUND_MAX);
                vfd_pkg::CONF_IDX:  item_next.confidence     = data[6:0];
                vfd_pkg::XLO_IDX:   item_next.offset_x[7:0]  = data;
                vfd_pkg::XHI_IDX:   item_next.offset_x[15:8] = data;
                vfd_pkg::YLO_IDX:   item_next.offset_y[7:0]  = data;
                vfd_pkg::YHI_IDX:   item_next.offset_y[15:8] = data;
                default:            item_next = item_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg        <= sum_next;
        ok_reg         <= ok_next;
        prev_hdr_reg   <= prev_hdr_next;
        pair_found_reg <= pair_found_next;
        pair_pos_reg   <= pair_pos_next;
        item_reg       <= item_next;
    end

    assign res.frame_ok   = ok_reg;
    assign res.pair_found = pair_found_reg;
    assign res.pair_pos   = pair_pos_reg;
    assign res.last_hdr   = prev_hdr_reg;
    assign item           = item_reg;

endmodule

@@ rtl/vfd_ctrl.sv @@
// Sequencer: fill count, check pass over the store, and resync copy.
// Drives vfd_store and vfd_check_unit. Depends on vfd_pkg.
`timescale 1ns / 1ps

module vfd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vfd_pkg::byte_t     rx_byte,
    input  vfd_pkg::byte_t     header_byte,
    input  logic               out_free,
    input  vfd_pkg::chk_res_t  res,
    input  vfd_pkg::byte_t     rd_data,
    output vfd_pkg::idx_t      rd_addr,
    output vfd_pkg::st_wr_t    wr,
    output vfd_pkg::chk_ctl_t  ctl,
    output logic               load_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PASS   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_COPY   = 2'd3;

    logic [1:0]    state_reg, state_next;
    vfd_pkg::idx_t fill_reg, fill_next;
    vfd_pkg::idx_t idx_reg, idx_next;
    vfd_pkg::idx_t shift_reg, shift_next;

    logic accept;
    logic rx_hdr;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rx_hdr   = (rx_byte == header_byte);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        rd_addr    = idx_reg;
        wr.we      = 1'b0;
        wr.addr    = fill_reg;
        wr.data    = rx_byte;
        ctl.step   = 1'b0;
        ctl.idx    = idx_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (fill_reg == vfd_pkg::HDR0_IDX) begin
                        // Hunt for the first header byte
                        if (rx_hdr) begin
                            wr.we     = 1'b1;
                            fill_next = vfd_pkg::idx_t'(1);
                        end
                    end else if (fill_reg == vfd_pkg::HDR1_IDX) begin
                        // Second header byte or drop the run
                        if (rx_hdr) begin
                            wr.we     = 1'b1;
                            fill_next = vfd_pkg::idx_t'(2);
                        end else begin
                            fill_next = '0;
                        end
                    end else if (fill_reg < vfd_pkg::LEN_IDX) begin
                        wr.we     = 1'b1;
                        fill_next = fill_reg + vfd_pkg::idx_t'(1);
                        if (fill_reg == vfd_pkg::LAST_IDX) begin
                            state_next = ST_PASS;
                            idx_next   = '0;
                        end
                    end else begin
                        fill_next = '0;
                    end
                end
            end
            ST_PASS: begin
                // Feed one stored byte per cycle into the check unit
                ctl.step = 1'b1;
                idx_next = idx_reg + vfd_pkg::idx_t'(1);
                if (idx_reg == vfd_pkg::LAST_IDX) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (res.frame_ok) begin
                    // Hold until the output register is free
                    if (out_free) begin
                        load_out   = 1'b1;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end else if (res.pair_found) begin
                    shift_next = res.pair_pos;
                    idx_next   = '0;
                    fill_next  = vfd_pkg::LEN_IDX - res.pair_pos;
                    state_next = ST_COPY;
                end else if (res.last_hdr) begin
                    // Keep a trailing header byte
                    wr.we      = 1'b1;
                    wr.addr    = vfd_pkg::HDR0_IDX;
                    wr.data    = header_byte;
                    fill_next  = vfd_pkg::idx_t'(1);
                    state_next = ST_IDLE;
                end else begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY: begin
                // Move the tail down to the new header pair, one byte a cycle
                rd_addr  = shift_reg + idx_reg;
                wr.we    = 1'b1;
                wr.addr  = idx_reg;
                wr.data  = rd_data;
                idx_next = idx_reg + vfd_pkg::idx_t'(1);
                if (idx_next == fill_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                fill_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
        end
    end

    // Fill count never reaches a full frame while waiting for bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> fill_reg < vfd_pkg::LEN_IDX)
        else $error("fill count out of range while idle");

    // A result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("result loaded over a pending item");

    // Copy source stays inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY |-> (shift_reg + idx_reg) < vfd_pkg::LEN_IDX)
        else $error("copy source beyond frame store");

    // A check pass starts only from a frame that just filled up
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PASS && idx_reg == '0 |-> fill_reg == vfd_pkg::LEN_IDX)
        else $error("check pass started on a partial frame");

endmodule

@@ rtl/vision_frame_deframer.sv @@
// Vision frame deframer: one received byte per item, one result per valid frame.
// The byte that completes a frame starts a check pass over the stored frame and a decide step;
// its result is loaded from the decide step, later while the output register is full.
// Throughput: one item per cycle while filling; s_tready stays low during the check pass,
// the decide step and, for a bad frame with a header pair inside, the resync copy.
// Synchronous reset clears fill count, sequencer and output valid; loads 0xAA / 0x55 registers.
`timescale 1ns / 1ps

module vision_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] has_target, [7:1] confidence,
                                   // [23:8] offset_x, [39:24] offset_y
);

    vfd_pkg::byte_t     header_reg, header_next;
    vfd_pkg::byte_t     tail_reg, tail_next;
    logic               m_tvalid_reg, m_tvalid_next;
    vfd_pkg::out_item_t m_item_reg, m_item_next;

    vfd_pkg::chk_res_t  res;
    vfd_pkg::chk_ctl_t  ctl;
    vfd_pkg::st_wr_t    wr;
    vfd_pkg::idx_t      rd_addr;
    vfd_pkg::byte_t     rd_data;
    vfd_pkg::out_item_t item;
    logic               load_out;
    logic               out_free;

    // Configuration writes
    always_comb begin
        header_next = header_reg;
        tail_next   = tail_reg;
        if (cfg_we) begin
            case (cfg_addr)
                vfd_pkg::CFG_HEADER: header_next = cfg_wdata;
                vfd_pkg::CFG_TAIL:   tail_next   = cfg_wdata;
                default:             header_next = header_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= vfd_pkg::HEADER_RESET;
            tail_reg   <= vfd_pkg::TAIL_RESET;
        end else begin
            header_reg <= header_next;
            tail_reg   <= tail_next;
        end
    end

    vfd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata),
        .header_byte (header_reg),
        .out_free    (out_free),
        .res         (res),
        .rd_data     (rd_data),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .ctl         (ctl),
        .load_out    (load_out)
    );

    vfd_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vfd_check_unit u_check (
        .aclk        (aclk),
        .ctl         (ctl),
        .data        (rd_data),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .res         (res),
        .item        (item)
    );

    // Output register: hold the item until taken
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_item_next   = m_item_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_item_next   = item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_item_reg;

endmodule
